>>> hdl/sacp_pkg.sv
package sacp_pkg;

    localparam int COUNT_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // latch address, read its set
        logic demand_cmp;  // compare demand tag, fill on miss
        logic pf_read;     // read set of next block
        logic pf_cmp;      // compare next-block tag, fill on miss
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic match;
        logic pf_en;
    } sts_t;

endpackage

>>> hdl/sacp_ctrl.sv
module sacp_ctrl
    import sacp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_PF_RD,
        S_PF_CMP
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_comb
    begin
        cmd.accept     = start && (state_reg == S_IDLE);
        cmd.demand_cmp = (state_reg == S_CMP);
        cmd.pf_read    = (state_reg == S_PF_RD);
        cmd.pf_cmp     = (state_reg == S_PF_CMP);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (sts.match || !sts.pf_en)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        state_reg <= S_PF_RD;
                end
                S_PF_RD:
                begin
                    state_reg <= S_PF_CMP;
                end
                S_PF_CMP:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted beat did not start a lookup");

    a_pf_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pf_read |=> (cmd.pf_cmp && !done))
        else $error("prefetch read not followed by compare");

endmodule

>>> hdl/sacp_dpath.sv
module sacp_dpath
    import sacp_pkg::*;
#(
    parameter int OFFSET_BITS  = 6,
    parameter int INDEX_BITS   = 6,
    parameter int WAYS         = 4,
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic                    cfg_write,
    input  logic                    cfg_data,
    output logic                    hit,
    output logic                    prefetch_filled,
    output logic [COUNT_W-1:0]      hit_count,
    output logic [COUNT_W-1:0]      miss_count
);

    localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int SET_COUNT = 1 << INDEX_BITS;
    localparam int PTR_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_RAW   = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int TAG_SHIFT = OFFSET_BITS + INDEX_BITS;

    logic [ADDRESS_BITS-1:0] look_addr_reg;
    logic                    pf_en_reg;
    logic                    hit_reg;
    logic                    pf_reg;
    logic [COUNT_W-1:0]      hits_reg;
    logic [COUNT_W-1:0]      misses_reg;

    logic [TAG_W-1:0] tag_mem    [SET_COUNT][WAYS];
    logic [TAG_W-1:0] rd_row_reg [WAYS];
    logic [WAYS-1:0]  valid_reg  [SET_COUNT];
    logic [PTR_W-1:0] fptr_reg   [SET_COUNT];

    logic [ADDRESS_BITS-1:0] in_shift;
    logic [ADDRESS_BITS-1:0] set_shift;
    logic [ADDRESS_BITS-1:0] tag_shift;
    logic [SET_W-1:0]        in_set;
    logic [SET_W-1:0]        cur_set;
    logic [SET_W-1:0]        rd_set;
    logic [TAG_W-1:0]        cur_tag;
    logic [WAYS-1:0]         vld_row;
    logic [WAYS-1:0]         match_vec;
    logic                    match;
    logic                    free_found;
    logic [PTR_W-1:0]        free_way;
    logic [PTR_W-1:0]        victim;
    logic [PTR_W-1:0]        victim_inc;
    logic                    fill_en;
    logic                    mem_re;

    // address split
    always_comb
    begin
        in_shift  = address >> OFFSET_BITS;
        set_shift = look_addr_reg >> OFFSET_BITS;
        tag_shift = look_addr_reg >> TAG_SHIFT;
        in_set    = (INDEX_BITS == 0) ? '0 : in_shift[SET_W-1:0];
        cur_set   = (INDEX_BITS == 0) ? '0 : set_shift[SET_W-1:0];
        cur_tag   = (TAG_RAW > 0) ? tag_shift[TAG_W-1:0] : '0;
        rd_set    = cmd.accept ? in_set : cur_set;
        mem_re    = cmd.accept || cmd.pf_read;
    end

    // compare and victim choice; lowest free way wins over the FIFO pointer
    always_comb
    begin
        vld_row    = valid_reg[cur_set];
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match_vec[w] = vld_row[w] && (rd_row_reg[w] == cur_tag);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!vld_row[w])
            begin
                free_found = 1'b1;
                free_way   = PTR_W'(w);
            end
        end
        match      = |match_vec;
        victim     = free_found ? free_way : fptr_reg[cur_set];
        victim_inc = (victim == PTR_W'(WAYS - 1)) ? '0 : victim + PTR_W'(1);
        fill_en    = (cmd.demand_cmp || cmd.pf_cmp) && !match;
    end

    assign sts.match = match;
    assign sts.pf_en = pf_en_reg;

    // tag memory: one row read per cycle, one way written per cycle
    always_ff @(posedge clk)
    begin
        if (fill_en)
            tag_mem[cur_set][victim] <= cur_tag;
        if (mem_re)
            rd_row_reg <= tag_mem[rd_set];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            look_addr_reg <= address;
        else if (cmd.demand_cmp && !match)
            look_addr_reg <= look_addr_reg + (ADDRESS_BITS'(1) << OFFSET_BITS);

        if (cmd.demand_cmp)
        begin
            hit_reg <= match;
            pf_reg  <= 1'b0;
        end
        else if (cmd.pf_cmp)
            pf_reg <= !match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_en_reg  <= 1'b0;
            hits_reg   <= '0;
            misses_reg <= '0;
            for (int s = 0; s < SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
                fptr_reg[s]  <= '0;
            end
        end
        else
        begin
            if (cfg_write)
                pf_en_reg <= cfg_data;
            if (cmd.demand_cmp && match && (hits_reg != '1))
                hits_reg <= hits_reg + COUNT_W'(1);
            if (fill_en && (misses_reg != '1))
                misses_reg <= misses_reg + COUNT_W'(1);
            if (fill_en)
            begin
                valid_reg[cur_set][victim] <= 1'b1;
                if (!free_found)
                    fptr_reg[cur_set] <= victim_inc;
            end
        end
    end

    assign hit             = hit_reg;
    assign prefetch_filled = pf_reg;
    assign hit_count       = hits_reg;
    assign miss_count      = misses_reg;

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(fill_en && mem_re))
        else $error("tag memory read and write in the same cycle");

    a_hits_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hits_reg != $past(hits_reg)) |-> $past(cmd.demand_cmp && match))
        else $error("hit count moved outside a demand hit");

    a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        (misses_reg != $past(misses_reg)) |->
            (misses_reg == $past(misses_reg) + COUNT_W'(1)))
        else $error("miss count moved by other than one");

endmodule

>>> hdl/set_assoc_cache_with_prefetch.sv
// Tag-only set-associative cache with FIFO replacement and next-block prefetch.
// Input: pulse start with address while busy is low; the beat is taken at that
// edge. Output: done is high for exactly one cycle with hit, prefetch_filled
// and the running saturating hit_count / miss_count; the receiver cannot stall,
// so the beat is taken at the edge that ends that cycle. The counters stay on
// hit_count / miss_count between beats.
// From the accept edge the controller runs S_CMP for a hit or a miss without
// prefetch, and S_CMP, S_PF_RD, S_PF_CMP for a miss with prefetch enabled, then
// raises done. busy drops in the done cycle, so a new address can follow then;
// one access is in flight at a time. The sequence is set by the tag memory,
// which has one registered read port: a set read, a compare/fill, and a second
// read/compare for the prefetch. cfg_write/cfg_data write the registered
// prefetch_enable; write it while idle. Reset (rst_n low, asynchronous) clears
// all valid bits, FIFO pointers, both counters and prefetch_enable; no clearing
// pass is needed, the block is ready as soon as reset is released.
module set_assoc_cache_with_prefetch
    import sacp_pkg::*;
#(
    parameter int OFFSET_BITS  = 6,
    parameter int INDEX_BITS   = 6,
    parameter int WAYS         = 4,
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic                    cfg_write,
    input  logic                    cfg_data,
    output logic                    done,
    output logic                    hit,
    output logic                    prefetch_filled,
    output logic [COUNT_W-1:0]      hit_count,
    output logic [COUNT_W-1:0]      miss_count
);

    cmd_t cmd;
    sts_t sts;

    sacp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sacp_dpath #(
        .OFFSET_BITS  (OFFSET_BITS),
        .INDEX_BITS   (INDEX_BITS),
        .WAYS         (WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .address         (address),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .hit             (hit),
        .prefetch_filled (prefetch_filled),
        .hit_count       (hit_count),
        .miss_count      (miss_count)
    );

endmodule

>>> tb/tb_set_assoc_cache_with_prefetch.sv
module tb_set_assoc_cache_with_prefetch;
    import sacp_pkg::*;

    localparam int OFFSET_BITS  = 6;
    localparam int INDEX_BITS   = 6;
    localparam int WAYS         = 4;
    localparam int ADDRESS_BITS = 48;
    localparam int SETS         = 1 << INDEX_BITS;
    localparam int TAG_W        = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int BLOCK_BYTES  = 1 << OFFSET_BITS;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 158;

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [TAG_W-1:0]        tag_t;
    typedef logic [INDEX_BITS-1:0]   set_t;

    typedef struct packed {
        logic               hit;
        logic               prefetch_filled;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } access_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    addr_t       address = '0;
    logic        cfg_write = 1'b0;
    logic        cfg_data = 1'b0;
    logic        done;
    logic        hit;
    logic        prefetch_filled;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;

    // shadow copy of the cache
    tag_t               way_tag   [SETS][WAYS];
    bit                 way_valid [SETS][WAYS];
    int                 fifo_ptr  [SETS];
    logic [COUNT_W-1:0] hits_seen;
    logic [COUNT_W-1:0] misses_seen;
    bit                 pf_enable;

    access_result_t pending_results[$];
    access_result_t oldest;
    int             errors;
    int             max_gap;

    tag_t  tag_pool [6];
    set_t  set_pool [4];
    addr_t stream_addr;

    set_assoc_cache_with_prefetch dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .address         (address),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .done            (done),
        .hit             (hit),
        .prefetch_filled (prefetch_filled),
        .hit_count       (hit_count),
        .miss_count      (miss_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    function automatic bit cache_lookup(input addr_t a);
        set_t s;
        bit   found;
        s = a[OFFSET_BITS +: INDEX_BITS];
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (way_valid[s][w] && way_tag[s][w] == a[ADDRESS_BITS-1 -: TAG_W])
                found = 1'b1;
        end
        return found;
    endfunction

    // lowest free way first, else FIFO victim
    function automatic void cache_fill(input addr_t a);
        set_t s;
        bit   placed;
        int   victim;
        s = a[OFFSET_BITS +: INDEX_BITS];
        placed = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!placed && !way_valid[s][w])
            begin
                way_tag[s][w]   = a[ADDRESS_BITS-1 -: TAG_W];
                way_valid[s][w] = 1'b1;
                placed = 1'b1;
            end
        end
        if (!placed)
        begin
            victim = fifo_ptr[s];
            way_tag[s][victim] = a[ADDRESS_BITS-1 -: TAG_W];
            fifo_ptr[s] = (victim + 1) % WAYS;
        end
    endfunction

    function automatic void predict_access(input addr_t a);
        access_result_t r;
        addr_t          next_blk;
        r = '0;
        if (cache_lookup(a))
        begin
            r.hit = 1'b1;
            hits_seen = sat_inc(hits_seen);
        end
        else
        begin
            cache_fill(a);
            if (pf_enable)
            begin
                next_blk = a + addr_t'(BLOCK_BYTES);  // wraps at the top of the space
                if (!cache_lookup(next_blk))
                begin
                    cache_fill(next_blk);
                    misses_seen = sat_inc(misses_seen);
                    r.prefetch_filled = 1'b1;
                end
            end
            misses_seen = sat_inc(misses_seen);
        end
        r.hit_count  = hits_seen;
        r.miss_count = misses_seen;
        pending_results.push_back(r);
    endfunction

    function automatic addr_t block_addr(input tag_t t, input set_t s);
        return {t, s, {OFFSET_BITS{1'b0}}};
    endfunction

    function automatic addr_t next_address();
        int          pick;
        logic [31:0] r1;
        logic [31:0] r2;
        addr_t       a;
        pick = $urandom_range(0, 99);
        r1 = $urandom;
        r2 = $urandom;
        if (pick < 60)
            a = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
                 r1[OFFSET_BITS-1:0]};
        else if (pick < 80)
        begin
            if ($urandom_range(0, 15) == 0)
                stream_addr = block_addr(tag_pool[$urandom_range(0, 5)],
                                         set_pool[$urandom_range(0, 3)]);
            else
                stream_addr = stream_addr + addr_t'(BLOCK_BYTES);
            a = stream_addr | addr_t'(r1[OFFSET_BITS-1:0]);
        end
        else
            a = {r2[15:0], r1};
        return a;
    endfunction

    task automatic send_access(input addr_t a);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        address <= a;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_access(a);
    endtask

    // only while idle: every beat in flight has come back
    task automatic write_prefetch(input bit en);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        pf_enable = en;
        cfg_write <= 1'b0;
    endtask

    task automatic test_fifo_replacement();
        write_prefetch(1'b0);
        send_access('0);
        send_access(addr_t'(48'h3F));
        send_access('1);
        send_access(block_addr(tag_t'(1), set_t'(0)));
        send_access(block_addr(tag_t'(2), set_t'(0)));
        send_access(block_addr(tag_t'(3), set_t'(0)));
        // set full: oldest way goes first
        send_access(block_addr(tag_t'(4), set_t'(0)));
        send_access('0);
        send_access(block_addr(tag_t'(2), set_t'(0)) | addr_t'(48'h15));
        send_access(block_addr(tag_t'(1), set_t'(0)));
    endtask

    task automatic test_prefetch_fill();
        write_prefetch(1'b1);
        send_access(addr_t'(48'hFFFF_FFFF_FFC0));
        send_access(addr_t'(48'hFFFF_FFFF_FF80));
        for (int t = 5; t < 9; t++)
            send_access(block_addr(tag_t'(t), set_t'(SETS - 1)));
        // top block missing again: next block wraps to address zero
        send_access('1);
        send_access('0);
        send_access(addr_t'(48'h1234_5678_9000));
        send_access(addr_t'(48'h1234_5678_9040));
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_prefetch((p % 2) == 0);
            max_gap = (p == 3) ? 0 : 9;
            foreach (tag_pool[i])
                tag_pool[i] = tag_t'({$urandom, $urandom});
            foreach (set_pool[i])
                set_pool[i] = set_t'($urandom_range(0, SETS - 1));
            stream_addr = block_addr(tag_pool[0], set_pool[0]);
            repeat (PHASE_ITEMS) send_access(next_address());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual hit=%0b", $time, hit);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (hit !== oldest.hit)
                begin
                    $display("%0t hit: expected %0b actual %0b", $time, oldest.hit, hit);
                    errors++;
                end
                if (prefetch_filled !== oldest.prefetch_filled)
                begin
                    $display("%0t prefetch_filled: expected %0b actual %0b", $time,
                             oldest.prefetch_filled, prefetch_filled);
                    errors++;
                end
                if (hit_count !== oldest.hit_count)
                begin
                    $display("%0t hit_count: expected %0d actual %0d", $time,
                             oldest.hit_count, hit_count);
                    errors++;
                end
                if (miss_count !== oldest.miss_count)
                begin
                    $display("%0t miss_count: expected %0d actual %0d", $time,
                             oldest.miss_count, miss_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int drain;
        errors = 0;
        max_gap = 9;
        hits_seen = '0;
        misses_seen = '0;
        pf_enable = 1'b0;
        for (int s = 0; s < SETS; s++)
        begin
            fifo_ptr[s] = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                way_valid[s][w] = 1'b0;
                way_tag[s][w]   = '0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_fifo_replacement();
        test_prefetch_fill();
        test_random_traffic();

        start <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t missing result beats: expected %0d more, actual 0", $time,
                     pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/sacp_pkg.sv
hdl/sacp_ctrl.sv
hdl/sacp_dpath.sv
hdl/set_assoc_cache_with_prefetch.sv
tb/tb_set_assoc_cache_with_prefetch.sv
